// File: rtl/core/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the mass-storage command/status core
// Opcodes, command classes, sense codes and the request records that travel
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package msc_pkg;

    // Wrapper and status codes
    localparam logic [31:0] WRAPPER_SIG      = 32'h4342_5355;
    localparam logic [1:0]  STATUS_GOOD      = 2'd0;
    localparam logic [1:0]  STATUS_FAILED    = 2'd1;
    localparam logic [1:0]  STATUS_PHASE_ERR = 2'd2;

    // Fixed reply length of request sense
    localparam logic [31:0] SENSE_REPLY_BYTES = 32'd18;

    // SCSI operation codes
    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
    localparam logic [7:0] OP_INQUIRY         = 8'h12;
    localparam logic [7:0] OP_MODE_SENSE      = 8'h1A;
    localparam logic [7:0] OP_READ_FMT_CAP    = 8'h23;
    localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
    localparam logic [7:0] OP_READ            = 8'h28;
    localparam logic [7:0] OP_WRITE           = 8'h2A;
    localparam logic [7:0] OP_VERIFY          = 8'h2F;

    // Medium-side outcomes
    localparam logic [2:0] OUTCOME_OK       = 3'd0;
    localparam logic [2:0] OUTCOME_NO_MEDIA = 3'd1;
    localparam logic [2:0] OUTCOME_CHANGED  = 3'd2;
    localparam logic [2:0] OUTCOME_INVALID  = 3'd4;

    // Sense keys
    localparam logic [3:0] KEY_NONE         = 4'd0;
    localparam logic [3:0] KEY_NOT_READY    = 4'd2;
    localparam logic [3:0] KEY_MEDIUM_ERROR = 4'd3;
    localparam logic [3:0] KEY_ILLEGAL      = 4'd5;
    localparam logic [3:0] KEY_ATTENTION    = 4'd6;

    // Additional sense codes
    localparam logic [7:0] ASC_NONE          = 8'h00;
    localparam logic [7:0] ASC_READ_ERROR    = 8'h11;
    localparam logic [7:0] ASC_WRITE_ERROR   = 8'h0C;
    localparam logic [7:0] ASC_BAD_OPCODE    = 8'h20;
    localparam logic [7:0] ASC_BAD_FIELD     = 8'h24;
    localparam logic [7:0] ASC_BAD_UNIT      = 8'h25;
    localparam logic [7:0] ASC_MEDIA_CHANGED = 8'h28;
    localparam logic [7:0] ASC_RESET         = 8'h29;
    localparam logic [7:0] ASC_NO_MEDIUM     = 8'h3A;

    // Command classes decided by the front end
    localparam logic [3:0] KIND_BAD     = 4'd0;  // broken wrapper, stall both
    localparam logic [3:0] KIND_MUTE    = 4'd1;  // reserved bits set, no effect
    localparam logic [3:0] KIND_UNIT    = 4'd2;  // unit out of range
    localparam logic [3:0] KIND_DIN_DIR = 4'd3;  // data-in command, wrong direction
    localparam logic [3:0] KIND_INQ     = 4'd4;
    localparam logic [3:0] KIND_RSENSE  = 4'd5;
    localparam logic [3:0] KIND_READ    = 4'd6;  // read or read capacity
    localparam logic [3:0] KIND_MSENSE  = 4'd7;
    localparam logic [3:0] KIND_RFC     = 4'd8;
    localparam logic [3:0] KIND_WR_DIR  = 4'd9;  // write, wrong direction
    localparam logic [3:0] KIND_WRITE   = 4'd10;
    localparam logic [3:0] KIND_TUR     = 4'd11; // test unit ready or verify
    localparam logic [3:0] KIND_UNSUP   = 4'd12;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classified request handed from front to back
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] tag;
        logic [31:0] len;
        logic [2:0]  outcome;
        logic [31:0] nbytes;   // byte count the command produced or needs
        logic [31:0] diff;     // len - nbytes
        logic        n_eq;     // nbytes == len
        logic        n_gt;     // nbytes > len
        logic        len_ge_sense;
    } cmd_t;

    // Status result
    typedef struct packed {
        logic        send_status;
        logic [31:0] status_tag;
        logic [1:0]  status_code;
        logic [31:0] residue;
        logic [31:0] data_bytes;
        logic        stall_in;
        logic        stall_out;
        logic [3:0]  report_key;
        logic [7:0]  report_asc;
        logic [7:0]  report_ascq;
    } res_t;

endpackage

// File: rtl/core/mass_storage_command_status_core.sv
// ----------------------------------------------------------------------------
// mass_storage_command_status_core: bulk-only mass-storage command/status
// Checks each command wrapper, executes it against the kept sense data and
// returns the status wrapper fields, data-phase count and stall requests.
//
//   channel | dir | bits | carries
//   s_      | in  | 152  | command wrapper, medium outcome, handler byte count
//   m_      | out | 128  | status wrapper, data count, stalls, reported sense
//
// One request per cycle sustained while m_ is not stalled; an accepted
// request passes the front register, the queue and the result register
// before m_tvalid rises. The sense update in the back end is registered
// as each request is taken, so requests follow each other with no gap.
// Reset sets the sense to unit attention, reset occurred; no clearing pass.
// A stall on m_ fills the result register, then the two-entry queue, then
// the front register before s_tready drops.
// ----------------------------------------------------------------------------
module mass_storage_command_status_core #(
    parameter int MAX_UNITS = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // wrapper_complete, signature, reserved_clear, unit_number, opcode,
    // direction_in, expected length, tag, outcome, handler_bytes, zero pad
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // send_status, status_tag, status_code, residue, data_bytes, stall_in,
    // stall_out, report_key, report_asc, report_ascq, zero pad
    output logic [127:0] m_tdata
);

    msc_pkg::cmd_t front_cmd;
    msc_pkg::cmd_t queue_cmd;
    logic          front_valid;
    logic          front_ready;
    logic          queue_valid;
    logic          queue_ready;
    msc_pkg::res_t res;

    // Accept and classify
    msc_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Decouple front and back
    msc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    // Execute and build status
    msc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result, first field in the lowest bits
    assign m_tdata = {7'd0, res.report_ascq, res.report_asc, res.report_key,
                      res.stall_out, res.stall_in, res.data_bytes, res.residue,
                      res.status_code, res.status_tag, res.send_status};

    // A dropped wrapper carries no status code and no residue
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.send_status |-> res.status_code == msc_pkg::STATUS_GOOD
                                         && res.residue == 32'd0 && res.data_bytes == 32'd0)
        else $error("dropped wrapper carries status fields");

    // A bulk-out stall on a sent status only comes with a phase error
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.send_status && res.stall_out
            |-> res.status_code == msc_pkg::STATUS_PHASE_ERR)
        else $error("bulk-out stall without phase error");

    // Reported sense only comes with a passed, sent status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.report_key != msc_pkg::KEY_NONE
                     || res.report_asc != msc_pkg::ASC_NONE
                     || res.report_ascq != 8'd0)
            |-> res.send_status && res.status_code == msc_pkg::STATUS_GOOD)
        else $error("sense reported outside a passed request sense");

    // Status code is never the unused encoding
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.status_code != 2'd3)
        else $error("illegal status code");

endmodule

// File: rtl/core/msc_front.sv
// ----------------------------------------------------------------------------
// msc_front: wrapper check and command classification
// Unpacks an input request, checks the wrapper, sorts the opcode into a
// command class and works out the byte-count compare, then holds the
// classified request in a register until the queue takes it.
// ----------------------------------------------------------------------------
module msc_front #(
    parameter int MAX_UNITS = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [151:0]      s_tdata,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output msc_pkg::cmd_t     cmd
);

    logic        wrapper_complete;
    logic [31:0] signature;
    logic        reserved_clear;
    logic [3:0]  unit_number;
    logic [7:0]  opcode;
    logic        direction_in;
    logic [31:0] host_len;
    logic [31:0] tag;
    logic [2:0]  outcome;
    logic [31:0] handler_bytes;

    logic [3:0]    kind;
    logic [31:0]   n_sel;
    logic [32:0]   sub;
    msc_pkg::cmd_t cmd_next;
    msc_pkg::cmd_t cmd_reg;
    logic          valid_reg;

    // Unpack the request
    assign wrapper_complete = s_tdata[0];
    assign signature        = s_tdata[32:1];
    assign reserved_clear   = s_tdata[33];
    assign unit_number      = s_tdata[37:34];
    assign opcode           = s_tdata[45:38];
    assign direction_in     = s_tdata[46];
    assign host_len         = s_tdata[78:47];
    assign tag              = s_tdata[110:79];
    assign outcome          = s_tdata[113:111];
    assign handler_bytes    = s_tdata[145:114];

    // Classify the command
    always_comb begin
        if (!wrapper_complete || signature != msc_pkg::WRAPPER_SIG) begin
            kind = msc_pkg::KIND_BAD;
        end else if (!reserved_clear) begin
            kind = msc_pkg::KIND_MUTE;
        end else if (32'(unit_number) >= 32'(MAX_UNITS)) begin
            kind = msc_pkg::KIND_UNIT;
        end else begin
            case (opcode)
                msc_pkg::OP_INQUIRY: begin
                    kind = direction_in ? msc_pkg::KIND_INQ : msc_pkg::KIND_DIN_DIR;
                end
                msc_pkg::OP_REQUEST_SENSE: begin
                    kind = direction_in ? msc_pkg::KIND_RSENSE : msc_pkg::KIND_DIN_DIR;
                end
                msc_pkg::OP_READ, msc_pkg::OP_READ_CAPACITY: begin
                    kind = direction_in ? msc_pkg::KIND_READ : msc_pkg::KIND_DIN_DIR;
                end
                msc_pkg::OP_MODE_SENSE: begin
                    kind = direction_in ? msc_pkg::KIND_MSENSE : msc_pkg::KIND_DIN_DIR;
                end
                msc_pkg::OP_READ_FMT_CAP: begin
                    kind = direction_in ? msc_pkg::KIND_RFC : msc_pkg::KIND_DIN_DIR;
                end
                msc_pkg::OP_WRITE: begin
                    kind = direction_in ? msc_pkg::KIND_WR_DIR : msc_pkg::KIND_WRITE;
                end
                msc_pkg::OP_TEST_UNIT_READY, msc_pkg::OP_VERIFY: begin
                    kind = msc_pkg::KIND_TUR;
                end
                default: begin
                    kind = msc_pkg::KIND_UNSUP;
                end
            endcase
        end
    end

    // Compare the byte count with the expected length in one subtract
    always_comb begin
        n_sel = (opcode == msc_pkg::OP_REQUEST_SENSE) ? msc_pkg::SENSE_REPLY_BYTES
                                                      : handler_bytes;
        sub   = {1'b0, host_len} - {1'b0, n_sel};

        cmd_next.kind         = kind;
        cmd_next.tag          = tag;
        cmd_next.len          = host_len;
        cmd_next.outcome      = outcome;
        cmd_next.nbytes       = n_sel;
        cmd_next.diff         = sub[31:0];
        cmd_next.n_gt         = sub[32];
        cmd_next.n_eq         = (sub == 33'd0);
        cmd_next.len_ge_sense = (host_len >= msc_pkg::SENSE_REPLY_BYTES);
    end

    // Hold the classified request until the queue takes it
    assign s_tready = !valid_reg || cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: rtl/core/msc_queue.sv
// ----------------------------------------------------------------------------
// msc_queue: short request queue between front and back
// A small circular buffer of classified requests so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module msc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  msc_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output msc_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (msc_pkg::QUEUE_DEPTH > 1) ? $clog2(msc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(msc_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(msc_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(msc_pkg::QUEUE_DEPTH);

    msc_pkg::cmd_t    slot_reg [msc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/msc_back.sv
// ----------------------------------------------------------------------------
// msc_back: command execution and status build
// Keeps the sense key and codes, carries out one classified request per
// cycle unless stalled and holds the status result in an output register.
// ----------------------------------------------------------------------------
module msc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  msc_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output msc_pkg::res_t res
);

    logic [3:0] key_reg, key_next;
    logic [7:0] asc_reg, asc_next;
    logic [7:0] ascq_reg, ascq_next;

    msc_pkg::res_t res_reg, res_next;
    logic          valid_reg;
    logic          blocked;
    logic          good;
    logic          finish;
    logic          take;

    assign blocked   = (key_reg == msc_pkg::KEY_ATTENTION);
    assign cmd_ready = !valid_reg || res_ready;
    assign take      = cmd_valid && cmd_ready;

    // Work out the result and the next sense
    always_comb begin
        key_next  = key_reg;
        asc_next  = asc_reg;
        ascq_next = ascq_reg;
        res_next  = '0;
        good      = 1'b1;
        finish    = 1'b0;

        res_next.send_status = 1'b1;
        res_next.status_tag  = cmd.tag;

        case (cmd.kind)
            msc_pkg::KIND_BAD: begin
                res_next           = '0;
                res_next.stall_in  = 1'b1;
                res_next.stall_out = 1'b1;
            end
            msc_pkg::KIND_MUTE: begin
                res_next = '0;
            end
            msc_pkg::KIND_UNIT: begin
                if (!blocked) begin
                    key_next  = msc_pkg::KEY_ILLEGAL;
                    asc_next  = msc_pkg::ASC_BAD_UNIT;
                    ascq_next = 8'h00;
                end
                res_next.status_code = msc_pkg::STATUS_FAILED;
                res_next.residue     = cmd.len;
            end
            msc_pkg::KIND_DIN_DIR: begin
                res_next.stall_in    = 1'b1;
                res_next.status_code = msc_pkg::STATUS_PHASE_ERR;
            end
            msc_pkg::KIND_WR_DIR: begin
                res_next.stall_out   = 1'b1;
                res_next.status_code = msc_pkg::STATUS_PHASE_ERR;
            end
            msc_pkg::KIND_INQ: begin
                finish = 1'b1;
                if (cmd.outcome == msc_pkg::OUTCOME_INVALID) begin
                    good = 1'b0;
                    if (!blocked) begin
                        key_next  = msc_pkg::KEY_ILLEGAL;
                        asc_next  = msc_pkg::ASC_BAD_FIELD;
                        ascq_next = 8'h00;
                    end
                end
            end
            msc_pkg::KIND_RSENSE: begin
                finish = 1'b1;
                if (cmd.len_ge_sense) begin
                    res_next.report_key  = key_reg;
                    res_next.report_asc  = asc_reg;
                    res_next.report_ascq = ascq_reg;
                    key_next  = msc_pkg::KEY_NONE;
                    asc_next  = msc_pkg::ASC_NONE;
                    ascq_next = 8'h00;
                end
            end
            msc_pkg::KIND_READ: begin
                finish = 1'b1;
                if (blocked) begin
                    good = 1'b0;
                end else if (cmd.outcome != msc_pkg::OUTCOME_OK) begin
                    good      = 1'b0;
                    ascq_next = 8'h00;
                    if (cmd.outcome == msc_pkg::OUTCOME_NO_MEDIA) begin
                        key_next = msc_pkg::KEY_NOT_READY;
                        asc_next = msc_pkg::ASC_NO_MEDIUM;
                    end else if (cmd.outcome == msc_pkg::OUTCOME_CHANGED) begin
                        key_next = msc_pkg::KEY_ATTENTION;
                        asc_next = msc_pkg::ASC_MEDIA_CHANGED;
                    end else begin
                        key_next = msc_pkg::KEY_MEDIUM_ERROR;
                        asc_next = msc_pkg::ASC_READ_ERROR;
                    end
                end
            end
            msc_pkg::KIND_MSENSE: begin
                finish = 1'b1;
                if (blocked) begin
                    good = 1'b0;
                end else if (cmd.outcome == msc_pkg::OUTCOME_INVALID) begin
                    good      = 1'b0;
                    key_next  = msc_pkg::KEY_ILLEGAL;
                    asc_next  = msc_pkg::ASC_BAD_FIELD;
                    ascq_next = 8'h00;
                end
            end
            msc_pkg::KIND_RFC: begin
                finish = 1'b1;
                good   = !blocked;
            end
            msc_pkg::KIND_WRITE: begin
                res_next.data_bytes = cmd.len;
                if (blocked) begin
                    good = 1'b0;
                end else if (cmd.outcome != msc_pkg::OUTCOME_OK) begin
                    good      = 1'b0;
                    ascq_next = 8'h00;
                    if (cmd.outcome == msc_pkg::OUTCOME_NO_MEDIA) begin
                        key_next = msc_pkg::KEY_NOT_READY;
                        asc_next = msc_pkg::ASC_NO_MEDIUM;
                    end else if (cmd.outcome == msc_pkg::OUTCOME_CHANGED) begin
                        key_next = msc_pkg::KEY_ATTENTION;
                        asc_next = msc_pkg::ASC_MEDIA_CHANGED;
                    end else begin
                        key_next = msc_pkg::KEY_MEDIUM_ERROR;
                        asc_next = msc_pkg::ASC_WRITE_ERROR;
                    end
                end
                if (!good) begin
                    res_next.status_code = msc_pkg::STATUS_FAILED;
                    res_next.residue     = cmd.len;
                end else if (!cmd.n_gt) begin
                    res_next.status_code = msc_pkg::STATUS_GOOD;
                    res_next.residue     = cmd.diff;
                end else begin
                    res_next.status_code = msc_pkg::STATUS_PHASE_ERR;
                end
            end
            msc_pkg::KIND_TUR: begin
                res_next.residue = cmd.len;
                if (blocked) begin
                    res_next.status_code = msc_pkg::STATUS_FAILED;
                end else if (cmd.outcome == msc_pkg::OUTCOME_OK) begin
                    res_next.status_code = msc_pkg::STATUS_GOOD;
                end else begin
                    res_next.status_code = msc_pkg::STATUS_FAILED;
                    if (cmd.outcome == msc_pkg::OUTCOME_NO_MEDIA) begin
                        key_next  = msc_pkg::KEY_NOT_READY;
                        asc_next  = msc_pkg::ASC_NO_MEDIUM;
                        ascq_next = 8'h00;
                    end else if (cmd.outcome == msc_pkg::OUTCOME_CHANGED) begin
                        key_next  = msc_pkg::KEY_ATTENTION;
                        asc_next  = msc_pkg::ASC_MEDIA_CHANGED;
                        ascq_next = 8'h00;
                    end else begin
                        // medium error, codes kept
                        key_next = msc_pkg::KEY_MEDIUM_ERROR;
                    end
                end
            end
            default: begin
                // unsupported opcode
                if (!blocked) begin
                    key_next  = msc_pkg::KEY_ILLEGAL;
                    asc_next  = msc_pkg::ASC_BAD_OPCODE;
                    ascq_next = 8'h00;
                end
                res_next.status_code = msc_pkg::STATUS_FAILED;
                res_next.residue     = cmd.len;
            end
        endcase

        // Close a data-in command
        if (finish) begin
            if (!good) begin
                res_next.stall_in    = 1'b1;
                res_next.status_code = msc_pkg::STATUS_FAILED;
                res_next.residue     = cmd.len;
            end else if (cmd.n_eq) begin
                res_next.data_bytes  = cmd.nbytes;
                res_next.status_code = msc_pkg::STATUS_GOOD;
            end else if (!cmd.n_gt) begin
                res_next.data_bytes  = cmd.nbytes;
                res_next.stall_in    = 1'b1;
                res_next.status_code = msc_pkg::STATUS_GOOD;
                res_next.residue     = cmd.diff;
            end else begin
                res_next.stall_in    = 1'b1;
                res_next.status_code = msc_pkg::STATUS_PHASE_ERR;
            end
        end
    end

    // Update sense state and the output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= msc_pkg::KEY_ATTENTION;
            asc_reg   <= msc_pkg::ASC_RESET;
            ascq_reg  <= 8'h00;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                key_reg  <= key_next;
                asc_reg  <= asc_next;
                ascq_reg <= ascq_next;
            end
            if (cmd_ready) begin
                valid_reg <= cmd_valid;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the mass-storage command/status core
// Drives command wrappers with their medium outcome and byte count, tracks
// the kept sense data in a local status predictor and compares every status
// result field by field. Directed tests come first, then random commands
// under four pacing phases on the request and result channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          UNITS            = 1;
    localparam logic [2:0]  OUTCOME_IO_ERROR = 3'd3;
    // cycles with no handshake on either side before the run is abandoned
    localparam int          QUIET_LIMIT      = 4000;
    localparam int          TAIL_CYCLES      = 10;

    // One command wrapper with its medium-side outcome
    typedef struct {
        logic        complete;
        logic [31:0] signature;
        logic        rsv_clear;
        logic [3:0]  unit;
        logic [7:0]  opcode;
        logic        dir_in;
        logic [31:0] len;
        logic [31:0] tag;
        logic [2:0]  outcome;
        logic [31:0] nbytes;
    } cbw_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // wrapper_complete, signature, reserved_clear, unit_number, opcode,
    // direction_in, expected length, tag, outcome, handler_bytes, zero pad
    logic [151:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // send_status, status_tag, status_code, residue, data_bytes, stall_in,
    // stall_out, report_key, report_asc, report_ascq, zero pad
    logic [127:0] m_tdata;

    // Sense data as the predictor keeps it
    logic [3:0]   kept_key;
    logic [7:0]   kept_asc;
    logic [7:0]   kept_ascq;

    msc_pkg::res_t pending_status[$];
    msc_pkg::res_t got_status;
    msc_pkg::res_t want_status;

    int           idle_pct       = 0;
    int           stall_pct      = 0;
    int           error_count    = 0;
    int           commands_sent  = 0;
    int           results_seen   = 0;
    int           reports_seen   = 0;
    int           quiet_cycles   = 0;

    always #5 aclk = ~aclk;

    mass_storage_command_status_core #(
        .MAX_UNITS(UNITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Status predictor
    // ------------------------------------------------------------------------
    function automatic void keep_sense(input logic [3:0] key, input logic [7:0] asc);
        kept_key  = key;
        kept_asc  = asc;
        kept_ascq = 8'h00;
    endfunction

    // Illegal-request sense never overwrites a pending unit attention
    function automatic void keep_sense_soft(input logic [3:0] key, input logic [7:0] asc);
        if (kept_key != msc_pkg::KEY_ATTENTION)
            keep_sense(key, asc);
    endfunction

    function automatic void note_media_fault(input logic [2:0] outcome, input logic writing);
        if (outcome == msc_pkg::OUTCOME_NO_MEDIA)
            keep_sense(msc_pkg::KEY_NOT_READY, msc_pkg::ASC_NO_MEDIUM);
        else if (outcome == msc_pkg::OUTCOME_CHANGED)
            keep_sense(msc_pkg::KEY_ATTENTION, msc_pkg::ASC_MEDIA_CHANGED);
        else if (writing)
            keep_sense(msc_pkg::KEY_MEDIUM_ERROR, msc_pkg::ASC_WRITE_ERROR);
        else
            keep_sense(msc_pkg::KEY_MEDIUM_ERROR, msc_pkg::ASC_READ_ERROR);
    endfunction

    function automatic msc_pkg::res_t predict_status(input cbw_t c);
        msc_pkg::res_t r;
        logic          blocked;
        logic          good;
        logic [31:0]   n;
        r       = '0;
        blocked = (kept_key == msc_pkg::KEY_ATTENTION);
        good    = 1'b1;
        n       = c.nbytes;

        // Broken wrapper: stall both endpoints, no status
        if (!c.complete || c.signature != msc_pkg::WRAPPER_SIG) begin
            r.stall_in  = 1'b1;
            r.stall_out = 1'b1;
            return r;
        end
        // Reserved bits set: drop silently
        if (!c.rsv_clear)
            return r;

        r.send_status = 1'b1;
        r.status_tag  = c.tag;

        if (c.unit >= UNITS) begin
            keep_sense_soft(msc_pkg::KEY_ILLEGAL, msc_pkg::ASC_BAD_UNIT);
            r.status_code = msc_pkg::STATUS_FAILED;
            r.residue     = c.len;
            return r;
        end

        case (c.opcode)
            msc_pkg::OP_INQUIRY, msc_pkg::OP_READ, msc_pkg::OP_READ_CAPACITY,
            msc_pkg::OP_REQUEST_SENSE, msc_pkg::OP_MODE_SENSE,
            msc_pkg::OP_READ_FMT_CAP: begin
                if (!c.dir_in) begin
                    r.stall_in    = 1'b1;
                    r.status_code = msc_pkg::STATUS_PHASE_ERR;
                    return r;
                end
                if (c.opcode == msc_pkg::OP_INQUIRY) begin
                    if (c.outcome == msc_pkg::OUTCOME_INVALID) begin
                        keep_sense_soft(msc_pkg::KEY_ILLEGAL, msc_pkg::ASC_BAD_FIELD);
                        good = 1'b0;
                    end
                end else if (c.opcode == msc_pkg::OP_REQUEST_SENSE) begin
                    n = msc_pkg::SENSE_REPLY_BYTES;
                    // report and clear only when the host takes the whole reply
                    if (c.len >= msc_pkg::SENSE_REPLY_BYTES) begin
                        r.report_key  = kept_key;
                        r.report_asc  = kept_asc;
                        r.report_ascq = kept_ascq;
                        keep_sense(msc_pkg::KEY_NONE, msc_pkg::ASC_NONE);
                    end
                end else if (blocked) begin
                    good = 1'b0;
                end else if (c.opcode == msc_pkg::OP_READ
                             || c.opcode == msc_pkg::OP_READ_CAPACITY) begin
                    if (c.outcome != msc_pkg::OUTCOME_OK) begin
                        note_media_fault(c.outcome, 1'b0);
                        good = 1'b0;
                    end
                end else if (c.opcode == msc_pkg::OP_MODE_SENSE) begin
                    if (c.outcome == msc_pkg::OUTCOME_INVALID) begin
                        keep_sense(msc_pkg::KEY_ILLEGAL, msc_pkg::ASC_BAD_FIELD);
                        good = 1'b0;
                    end
                end
                // settle the data-in phase
                if (!good) begin
                    r.stall_in    = 1'b1;
                    r.status_code = msc_pkg::STATUS_FAILED;
                    r.residue     = c.len;
                end else if (n == c.len) begin
                    r.data_bytes  = n;
                    r.status_code = msc_pkg::STATUS_GOOD;
                end else if (n < c.len) begin
                    r.data_bytes  = n;
                    r.stall_in    = 1'b1;
                    r.status_code = msc_pkg::STATUS_GOOD;
                    r.residue     = c.len - n;
                end else begin
                    r.stall_in    = 1'b1;
                    r.status_code = msc_pkg::STATUS_PHASE_ERR;
                end
            end
            msc_pkg::OP_WRITE: begin
                if (c.dir_in) begin
                    r.stall_out   = 1'b1;
                    r.status_code = msc_pkg::STATUS_PHASE_ERR;
                    return r;
                end
                // the whole host transfer is taken in either way
                r.data_bytes = c.len;
                if (blocked) begin
                    good = 1'b0;
                end else if (c.outcome != msc_pkg::OUTCOME_OK) begin
                    note_media_fault(c.outcome, 1'b1);
                    good = 1'b0;
                end
                if (!good) begin
                    r.status_code = msc_pkg::STATUS_FAILED;
                    r.residue     = c.len;
                end else if (n <= c.len) begin
                    r.status_code = msc_pkg::STATUS_GOOD;
                    r.residue     = c.len - n;
                end else begin
                    r.status_code = msc_pkg::STATUS_PHASE_ERR;
                end
            end
            msc_pkg::OP_TEST_UNIT_READY, msc_pkg::OP_VERIFY: begin
                r.residue = c.len;
                if (blocked) begin
                    r.status_code = msc_pkg::STATUS_FAILED;
                end else if (c.outcome == msc_pkg::OUTCOME_OK) begin
                    r.status_code = msc_pkg::STATUS_GOOD;
                end else begin
                    r.status_code = msc_pkg::STATUS_FAILED;
                    // other faults change only the key, codes stay
                    if (c.outcome == msc_pkg::OUTCOME_NO_MEDIA
                        || c.outcome == msc_pkg::OUTCOME_CHANGED)
                        note_media_fault(c.outcome, 1'b0);
                    else
                        kept_key = msc_pkg::KEY_MEDIUM_ERROR;
                end
            end
            default: begin
                keep_sense_soft(msc_pkg::KEY_ILLEGAL, msc_pkg::ASC_BAD_OPCODE);
                r.status_code = msc_pkg::STATUS_FAILED;
                r.residue     = c.len;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic cbw_t mk_cbw(input logic [7:0] opcode, input logic dir_in,
                                    input logic [31:0] len, input logic [31:0] nbytes,
                                    input logic [2:0] outcome);
        cbw_t c;
        c.complete  = 1'b1;
        c.signature = msc_pkg::WRAPPER_SIG;
        c.rsv_clear = 1'b1;
        c.unit      = 4'd0;
        c.opcode    = opcode;
        c.dir_in    = dir_in;
        c.len       = len;
        c.tag       = $urandom;
        c.outcome   = outcome;
        c.nbytes    = nbytes;
        return c;
    endfunction

    // Send one request, predict its status once it is taken
    task automatic send_command(input cbw_t c);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, c.nbytes, c.outcome, c.tag, c.len, c.dir_in, c.opcode,
                     c.unit, c.rsv_clear, c.signature, c.complete};
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(predict_status(c));
        commands_sent++;
    endtask

    // Hold off the request side until every status has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    task automatic report_error(input string what);
        error_count++;
        if (error_count <= 40)
            $display("ERROR %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %h, wanted %h",
                                   results_seen, name, got, want));
    endtask

    // Randomly stall the result channel
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Compare each status with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_status.send_status = m_tdata[0];
            got_status.status_tag  = m_tdata[32:1];
            got_status.status_code = m_tdata[34:33];
            got_status.residue     = m_tdata[66:35];
            got_status.data_bytes  = m_tdata[98:67];
            got_status.stall_in    = m_tdata[99];
            got_status.stall_out   = m_tdata[100];
            got_status.report_key  = m_tdata[104:101];
            got_status.report_asc  = m_tdata[112:105];
            got_status.report_ascq = m_tdata[120:113];
            if (pending_status.size() == 0) begin
                report_error($sformatf("status with nothing outstanding: %h", m_tdata));
            end else begin
                want_status = pending_status.pop_front();
                check_field("send_status", 32'(got_status.send_status),
                            32'(want_status.send_status));
                check_field("status_tag", got_status.status_tag, want_status.status_tag);
                check_field("status_code", 32'(got_status.status_code),
                            32'(want_status.status_code));
                check_field("residue", got_status.residue, want_status.residue);
                check_field("data_bytes", got_status.data_bytes, want_status.data_bytes);
                check_field("stall_in", 32'(got_status.stall_in),
                            32'(want_status.stall_in));
                check_field("stall_out", 32'(got_status.stall_out),
                            32'(want_status.stall_out));
                check_field("report_key", 32'(got_status.report_key),
                            32'(want_status.report_key));
                check_field("report_asc", 32'(got_status.report_asc),
                            32'(want_status.report_asc));
                check_field("report_ascq", 32'(got_status.report_ascq),
                            32'(want_status.report_ascq));
                if (want_status.report_key != msc_pkg::KEY_NONE
                    || want_status.report_asc != msc_pkg::ASC_NONE)
                    reports_seen++;
            end
            results_seen++;
        end
    end

    // Abandon the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Unit attention after reset blocks media commands until request sense
    task automatic test_attention_after_reset();
        send_command(mk_cbw(msc_pkg::OP_READ, 1'b1, 32'd512, 32'd512,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_INQUIRY, 1'b1, 32'd36, 32'd36,
                            msc_pkg::OUTCOME_INVALID));
        send_command(mk_cbw(msc_pkg::OP_REQUEST_SENSE, 1'b1, 32'd18, 32'd0,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_MODE_SENSE, 1'b1, 32'd4, 32'd4,
                            msc_pkg::OUTCOME_INVALID));
    endtask

    // Incomplete wrapper, wrong signature, reserved bits set and a unit out of range
    task automatic test_broken_wrappers();
        cbw_t c;
        c = mk_cbw(msc_pkg::OP_READ, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   msc_pkg::OUTCOME_OK);
        c.complete = 1'b0;
        send_command(c);
        c = mk_cbw(msc_pkg::OP_WRITE, 1'b0, 32'd0, 32'd0, msc_pkg::OUTCOME_OK);
        c.signature = 32'hFFFF_FFFF;
        send_command(c);
        c = mk_cbw(msc_pkg::OP_INQUIRY, 1'b1, 32'd36, 32'd36, msc_pkg::OUTCOME_OK);
        c.rsv_clear = 1'b0;
        send_command(c);
        c = mk_cbw(msc_pkg::OP_READ, 1'b1, 32'd8, 32'd8, msc_pkg::OUTCOME_OK);
        c.unit = 4'hF;
        send_command(c);
    endtask

    // Data-in commands: direction, byte-count cases and medium faults
    task automatic test_data_in();
        send_command(mk_cbw(msc_pkg::OP_READ, 1'b0, 32'd64, 32'd64,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_READ, 1'b1, 32'd64, 32'd64,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_READ_CAPACITY, 1'b1, 32'd64, 32'd8,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_READ, 1'b1, 32'd0, 32'hFFFF_FFFF,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_READ_CAPACITY, 1'b1, 32'd8, 32'd8,
                            OUTCOME_IO_ERROR));
        send_command(mk_cbw(msc_pkg::OP_READ_FMT_CAP, 1'b1, 32'd12, 32'd12,
                            OUTCOME_IO_ERROR));
        send_command(mk_cbw(msc_pkg::OP_READ, 1'b1, 32'd512, 32'd512,
                            msc_pkg::OUTCOME_NO_MEDIA));
        send_command(mk_cbw(msc_pkg::OP_REQUEST_SENSE, 1'b1, 32'd17, 32'd0,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_REQUEST_SENSE, 1'b1, 32'hFFFF_FFFF, 32'd0,
                            msc_pkg::OUTCOME_OK));
    endtask

    // Write: direction, medium change, blocked write, byte counts and a write error
    task automatic test_write();
        send_command(mk_cbw(msc_pkg::OP_WRITE, 1'b1, 32'd512, 32'd512,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_WRITE, 1'b0, 32'd512, 32'd512,
                            msc_pkg::OUTCOME_CHANGED));
        send_command(mk_cbw(msc_pkg::OP_WRITE, 1'b0, 32'd512, 32'd512,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_REQUEST_SENSE, 1'b1, 32'd18, 32'd0,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_WRITE, 1'b0, 32'hFFFF_FFFF, 32'd0,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_WRITE, 1'b0, 32'd16, 32'd17,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_WRITE, 1'b0, 32'd16, 32'd16,
                            OUTCOME_IO_ERROR));
    endtask

    // Test unit ready, verify and an unsupported opcode
    task automatic test_ready_and_unsupported();
        send_command(mk_cbw(msc_pkg::OP_TEST_UNIT_READY, 1'b0, 32'd0, 32'd0,
                            msc_pkg::OUTCOME_OK));
        send_command(mk_cbw(msc_pkg::OP_VERIFY, 1'b0, 32'd4096, 32'd0,
                            msc_pkg::OUTCOME_INVALID));
        send_command(mk_cbw(msc_pkg::OP_TEST_UNIT_READY, 1'b1, 32'd0, 32'd0,
                            msc_pkg::OUTCOME_NO_MEDIA));
        send_command(mk_cbw(8'hFF, 1'b1, 32'd100, 32'd0, msc_pkg::OUTCOME_OK));
    endtask

    // Mostly well-formed commands with random content, some broken ones
    task automatic test_random(input int count, input int idle, input int stall);
        cbw_t c;
        logic in_cmd;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) begin
            // pick a command, weighted towards request sense to clear sense
            case ($urandom_range(14))
                0, 1, 2: c.opcode = msc_pkg::OP_REQUEST_SENSE;
                3:       c.opcode = msc_pkg::OP_INQUIRY;
                4, 5:    c.opcode = msc_pkg::OP_READ;
                6:       c.opcode = msc_pkg::OP_READ_CAPACITY;
                7:       c.opcode = msc_pkg::OP_MODE_SENSE;
                8:       c.opcode = msc_pkg::OP_READ_FMT_CAP;
                9, 10:   c.opcode = msc_pkg::OP_WRITE;
                11:      c.opcode = msc_pkg::OP_TEST_UNIT_READY;
                12:      c.opcode = msc_pkg::OP_VERIFY;
                default: c.opcode = 8'($urandom_range(255));
            endcase
            in_cmd = (c.opcode == msc_pkg::OP_WRITE) ? 1'b0 :
                     (c.opcode == msc_pkg::OP_TEST_UNIT_READY
                      || c.opcode == msc_pkg::OP_VERIFY) ?
                     1'($urandom_range(1)) : 1'b1;
            c.dir_in = ($urandom_range(9) == 0) ? ~in_cmd : in_cmd;
            case ($urandom_range(9))
                0:       c.len = 32'd0;
                1:       c.len = 32'hFFFF_FFFF;
                2, 3:    c.len = $urandom;
                4:       c.len = $urandom_range(20, 16);
                default: c.len = $urandom_range(64);
            endcase
            case ($urandom_range(5))
                0, 1: c.nbytes = c.len;
                2:    c.nbytes = c.len - 32'd1;
                3:    c.nbytes = c.len + 32'd1;
                4:    c.nbytes = $urandom;
                default: c.nbytes = $urandom_range(64);
            endcase
            c.outcome   = ($urandom_range(9) < 6) ? msc_pkg::OUTCOME_OK
                                                  : 3'($urandom_range(4, 1));
            c.tag       = $urandom;
            c.complete  = 1'b1;
            c.signature = msc_pkg::WRAPPER_SIG;
            c.rsv_clear = 1'b1;
            c.unit      = 4'd0;
            // break some wrappers
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(4))
                    0: c.complete  = 1'b0;
                    1: c.signature = c.signature ^ (32'd1 << $urandom_range(31));
                    2: c.signature = $urandom;
                    3: c.rsv_clear = 1'b0;
                    default: c.unit = 4'($urandom_range(15, 1));
                endcase
            end
            send_command(c);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        keep_sense(msc_pkg::KEY_ATTENTION, msc_pkg::ASC_RESET);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_attention_after_reset();
        test_broken_wrappers();
        hold_until_drained();
        test_data_in();
        test_write();
        test_ready_and_unsupported();
        test_random(350, 0, 0);
        hold_until_drained();
        test_random(350, 85, 0);
        test_random(350, 0, 85);
        test_random(350, 31, 31);
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_status.size() != 0)
            report_error($sformatf("%0d status results never arrived",
                                   pending_status.size()));
        $display("Sent %0d command wrappers; checked %0d status results (%0d with sense)",
                 commands_sent, results_seen, reports_seen);
        $display("Pacing: free-running, idle requester, stalled receiver, both; %0d errors",
                 error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
